@@ rtl/core/spq_pkg.sv @@
// Shared types and constants for the sorted priority task queue.
`default_nettype none

package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                 ins;
    logic                 pop;
    logic                 rem;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// One slot of the queue: holds a task and shifts toward either neighbor.
`default_nettype none

module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire spq_pkg::op_t    op,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  input  wire logic            left_ahead,
  input  wire logic            match_in,
  output spq_pkg::entry_t      entry,
  output logic                 ahead,
  output logic                 match_out,
  output spq_pkg::entry_t      sel_entry
);

  spq_pkg::entry_t entry_next;
  logic            hit;

  assign ahead     = entry.valid && (entry.prio > op.prio);
  assign hit       = entry.valid && (entry.id == op.id);
  assign match_out = match_in | hit;
  assign sel_entry = (hit && !match_in) ? entry : '0;

  always_comb begin
    entry_next = entry;
    if (op.ins) begin
      if (!ahead) begin
        if (left_ahead) begin
          entry_next.valid = 1'b1;
          entry_next.id    = op.id;
          entry_next.prio  = op.prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (op.pop) begin
      entry_next = right_entry;
    end else if (op.rem && match_out) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry.id   <= entry_next.id;
    entry.prio <= entry_next.prio;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sorted_priority_task_queue.sv @@
// Top level of the sorted priority task queue: a row of slot cells and the result register.
`default_nettype none

// The queue keeps up to 16 tasks in a row of cells ordered from highest to lowest
// priority, and every cell compares and shifts in the same cycle, so one request is
// taken per clock. Its result appears in the output register on the next cycle and
// holds there while the output is stalled; a new request is taken whenever that
// register is empty or its result is transferred in the same cycle. Equal priorities
// leave newest first, and a remove deletes the first matching identifier in priority
// order.
module sorted_priority_task_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    action,
  input  wire logic [spq_pkg::ID_BITS-1:0]   task_id,
  input  wire logic [spq_pkg::PRIO_BITS-1:0] priority_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [spq_pkg::ID_BITS-1:0]        out_task_id,
  output logic [spq_pkg::PRIO_BITS-1:0]      out_priority,
  output logic [spq_pkg::CNT_BITS-1:0]       occupancy
);

  localparam int D = spq_pkg::DEPTH;

  spq_pkg::entry_t              entries   [D];
  spq_pkg::entry_t              sels      [D];
  spq_pkg::entry_t              lefts     [D];
  spq_pkg::entry_t              rights    [D];
  logic [D:0]                   ahead_chain;
  logic [D:0]                   match_chain;
  spq_pkg::op_t                 op;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [spq_pkg::CNT_BITS-1:0] count;
  logic [spq_pkg::CNT_BITS-1:0] count_next;
  spq_pkg::status_t             status_next;
  spq_pkg::entry_t              removed;
  spq_pkg::entry_t              found;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == spq_pkg::CNT_BITS'(D));
  assign empty    = (count == '0);

  assign op.ins  = accept && (action == spq_pkg::ACT_INSERT) && !full;
  assign op.pop  = accept && (action == spq_pkg::ACT_POP) && !empty;
  assign op.rem  = accept && (action == spq_pkg::ACT_REMOVE);
  assign op.id   = task_id;
  assign op.prio = priority_req;

  assign ahead_chain[0] = 1'b1;
  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
    end else begin : g_mid
      assign lefts[i] = entries[i-1];
    end
    if (i == D - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_entry  (lefts[i]),
      .right_entry (rights[i]),
      .left_ahead  (ahead_chain[i]),
      .match_in    (match_chain[i]),
      .entry       (entries[i]),
      .ahead       (ahead_chain[i+1]),
      .match_out   (match_chain[i+1]),
      .sel_entry   (sels[i])
    );
  end

  always_comb begin
    found = '0;
    for (int i = 0; i < D; i++) begin
      found = found | sels[i];
    end
  end

  always_comb begin
    status_next = spq_pkg::ST_OK;
    removed     = '0;
    count_next  = count;
    unique case (spq_pkg::action_t'(action))
      spq_pkg::ACT_INSERT: begin
        if (full) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      spq_pkg::ACT_POP: begin
        if (empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          removed    = entries[0];
          count_next = count - 1'b1;
        end
      end
      spq_pkg::ACT_REMOVE: begin
        if (empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else if (!match_chain[D]) begin
          status_next = spq_pkg::ST_NOT_FOUND;
        end else begin
          removed    = found;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      out_task_id  <= removed.id;
      out_priority <= removed.prio;
      occupancy    <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_BITS'(D))
    else $error("occupancy exceeds depth");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    entries[0].valid == (count != '0))
    else $error("head cell valid disagrees with occupancy");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    entries[1].valid |-> (entries[0].valid && entries[0].prio >= entries[1].prio))
    else $error("head of queue out of priority order");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow occupancy");

endmodule

`default_nettype wire

@@ tb/sv/sorted_priority_task_queue_test.sv @@
// Testbench for the sorted priority task queue: random and directed requests checked
// against a shadow queue.
`timescale 1ns / 100ps

module sorted_priority_task_queue_test;

  localparam int DEPTH          = spq_pkg::DEPTH;
  localparam int ID_BITS        = spq_pkg::ID_BITS;
  localparam int PRIO_BITS      = spq_pkg::PRIO_BITS;
  localparam int CNT_BITS       = spq_pkg::CNT_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 90;
  localparam int PHASE_ITEMS    = 205;

  typedef struct {
    spq_pkg::status_t     st;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [CNT_BITS-1:0]  occ;
  } answer_t;

  class queue_shadow;
    logic [ID_BITS-1:0]   ids[DEPTH];
    logic [PRIO_BITS-1:0] prios[DEPTH];
    int unsigned          count;
    answer_t              awaited[$];
    int unsigned          mismatches, requests, answers;
    int unsigned          stored, turned_away, taken, missed, empty_hits;

    function void close_gap(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        ids[i]   = ids[i + 1];
        prios[i] = prios[i + 1];
      end
      count--;
    endfunction

    function logic [ID_BITS-1:0] stored_id(int unsigned k);
      if (count == 0) return ID_BITS'(k);
      return ids[k % count];
    endfunction

    function void take_request(spq_pkg::action_t act, logic [ID_BITS-1:0] id,
                               logic [PRIO_BITS-1:0] prio);
      answer_t a;
      int      pos;
      a.st   = spq_pkg::ST_OK;
      a.id   = '0;
      a.prio = '0;
      requests++;
      case (act)
        spq_pkg::ACT_INSERT: begin
          if (count == DEPTH) begin
            a.st = spq_pkg::ST_FULL;
            turned_away++;
          end else begin
            pos = 0;
            while (pos < count && prios[pos] > prio) pos++;
            for (int i = count; i > pos; i--) begin
              ids[i]   = ids[i - 1];
              prios[i] = prios[i - 1];
            end
            ids[pos]   = id;
            prios[pos] = prio;
            count++;
            stored++;
          end
        end
        spq_pkg::ACT_POP, spq_pkg::ACT_REMOVE: begin
          if (count == 0) begin
            a.st = spq_pkg::ST_EMPTY;
            empty_hits++;
          end else begin
            pos = -1;
            if (act == spq_pkg::ACT_POP) begin
              pos = 0;
            end else begin
              for (int i = 0; i < count; i++) begin
                if (ids[i] == id) begin
                  pos = i;
                  break;
                end
              end
            end
            if (pos < 0) begin
              a.st = spq_pkg::ST_NOT_FOUND;
              missed++;
            end else begin
              a.id   = ids[pos];
              a.prio = prios[pos];
              close_gap(pos);
              taken++;
            end
          end
        end
        default: begin
        end
      endcase
      a.occ = CNT_BITS'(count);
      awaited.push_back(a);
    endfunction

    function void match_response(logic [1:0] st, logic [ID_BITS-1:0] id,
                                 logic [PRIO_BITS-1:0] prio, logic [CNT_BITS-1:0] occ);
      answer_t a;
      answers++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result st=%0d id=%h prio=%0d occ=%0d with no request outstanding",
                   $realtime, st, id, prio, occ);
        return;
      end
      a = awaited.pop_front();
      if (st !== a.st || id !== a.id || prio !== a.prio || occ !== a.occ) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected st=%0d id=%h prio=%0d occ=%0d, %s",
                   $realtime, a.st, a.id, a.prio, a.occ,
                   $sformatf("got st=%0d id=%h prio=%0d occ=%0d", st, id, prio, occ));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           action;
  logic [ID_BITS-1:0]   task_id;
  logic [PRIO_BITS-1:0] priority_req;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic [ID_BITS-1:0]   out_task_id;
  logic [PRIO_BITS-1:0] out_priority;
  logic [CNT_BITS-1:0]  occupancy;

  queue_shadow sb = new();
  int          sender_idle;
  int          stall_pct;
  int          hold_left;
  int          ins_pct;
  int          quiet_cycles;
  int          phase_idle[4]  = '{0, 50, 0, 19};
  int          phase_stall[4] = '{0, 0, 50, 19};

  sorted_priority_task_queue u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.match_response(status, out_task_id, out_priority, occupancy);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_priority_task_queue_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input spq_pkg::action_t act, input logic [ID_BITS-1:0] id,
                              input logic [PRIO_BITS-1:0] prio);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    task_id      <= id;
    priority_req <= prio;
    do @(posedge clk); while (in_stall);
    sb.take_request(act, id, prio);
    @(negedge clk);
  endtask

  task automatic send_random(input int weight);
    spq_pkg::action_t     act;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    int                   r;
    r    = $urandom_range(99);
    id   = ID_BITS'($urandom);
    prio = PRIO_BITS'($urandom);
    if (r < 3) act = spq_pkg::ACT_NONE;
    else if (r < 3 + weight) act = spq_pkg::ACT_INSERT;
    else if (r[0]) act = spq_pkg::ACT_POP;
    else act = spq_pkg::ACT_REMOVE;
    if (act == spq_pkg::ACT_INSERT) begin
      case ($urandom_range(9))
        0: id = '0;
        1: id = '1;
        2, 3, 4, 5: id = ID_BITS'($urandom_range(31));
        default: begin
        end
      endcase
      case ($urandom_range(9))
        0: prio = '0;
        1: prio = '1;
        2, 3, 4, 5: prio = PRIO_BITS'($urandom_range(3));
        default: begin
        end
      endcase
    end else if (act == spq_pkg::ACT_REMOVE) begin
      if ($urandom_range(9) < 7) id = sb.stored_id($urandom);
      else if ($urandom_range(1) == 0) id = ID_BITS'($urandom_range(31));
    end
    send_request(act, id, prio);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = spq_pkg::ACT_NONE;
    task_id      = '0;
    priority_req = '0;
    sender_idle  = 0;
    stall_pct    = 0;
    hold_left    = 0;
    ins_pct      = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(spq_pkg::ACT_POP, 16'h0000, 8'd0);
    send_request(spq_pkg::ACT_REMOVE, 16'h0055, 8'd0);
    send_request(spq_pkg::ACT_NONE, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::ACT_INSERT, 16'hFFFF, 8'd255);
    send_request(spq_pkg::ACT_INSERT, 16'h0000, 8'd0);
    send_request(spq_pkg::ACT_INSERT, 16'h1234, 8'd128);
    send_request(spq_pkg::ACT_INSERT, 16'h1235, 8'd128);
    send_request(spq_pkg::ACT_INSERT, 16'h1234, 8'd200);
    send_request(spq_pkg::ACT_INSERT, 16'h0001, 8'd255);
    send_request(spq_pkg::ACT_INSERT, 16'h0002, 8'd0);
    for (int i = 0; i < 9; i++)
      send_request(spq_pkg::ACT_INSERT, 16'hA000 + ID_BITS'(i), PRIO_BITS'(i * 31));
    send_request(spq_pkg::ACT_INSERT, 16'h4321, 8'd77);
    send_request(spq_pkg::ACT_REMOVE, 16'h9999, 8'd0);
    send_request(spq_pkg::ACT_REMOVE, 16'h1234, 8'd0);
    send_request(spq_pkg::ACT_NONE, 16'h0000, 8'd0);
    send_request(spq_pkg::ACT_POP, 16'h0000, 8'd0);

    for (int ph = 0; ph < 4; ph++) begin
      pause_until_drained();
      sender_idle = phase_idle[ph];
      stall_pct   = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0: ins_pct = 85;
            1: ins_pct = 50;
            default: ins_pct = 20;
          endcase
        end
        // Hold the output off for a long stretch while requests keep coming.
        if (ph == 0 && n == 100) begin
          hold_left = HOLD_CYCLES;
          repeat (8) send_random(85);
        end
        send_random(ins_pct);
      end
    end

    pause_until_drained();
    repeat (20) @(negedge clk);
    $display("Run covered %0d requests and %0d results: %0d stored, %0d rejected as full,",
             sb.requests, sb.answers, sb.stored, sb.turned_away);
    $display("%0d taken by pop or remove, %0d removes not found, %0d on an empty queue.",
             sb.taken, sb.missed, sb.empty_hits);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("sorted_priority_task_queue_test: done, clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("sorted_priority_task_queue_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sorted_priority_task_queue.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_task_queue.sv
tb/sv/sorted_priority_task_queue_test.sv
